FILE: design/positional_record_list_defines.svh
// assertion macros used by the positional record list sequencer
`ifndef POSITIONAL_RECORD_LIST_DEFINES_SVH
`define POSITIONAL_RECORD_LIST_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent and consequent in the same cycle
`define PRL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// consequent in the cycle after the antecedent
`define PRL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PRL_ASSERT_SAME(label, ante, cons, msg)
`define PRL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: design/prl_pkg.sv
// types and constants of the positional record list
`default_nettype none
package prl_pkg;

	localparam int POS_W       = 9;
	localparam int TOUCH_W     = 9;
	localparam int OUT_COUNT_W = 10;

	localparam logic [2:0] CMD_APPEND = 3'd0;
	localparam logic [2:0] CMD_INSERT = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_UPDATE = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;
	localparam logic [1:0] ST_NOKEY  = 2'd3;

	typedef struct packed {
		logic [2:0]  command;
		logic [8:0]  position;
		logic [7:0]  match_size;
		logic [7:0]  item_size;
		logic [23:0] item_price;
		logic [63:0] color_w0;
		logic [63:0] color_w1;
		logic [31:0] color_w2;
		logic [63:0] brand_w0;
		logic [63:0] brand_w1;
		logic [31:0] brand_w2;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] touched_index;
		logic [9:0] entry_count;
	} res_t;

	typedef struct packed {
		logic [7:0]  size;
		logic [23:0] price;
		logic [63:0] color_w0;
		logic [63:0] color_w1;
		logic [31:0] color_w2;
		logic [63:0] brand_w0;
		logic [63:0] brand_w1;
		logic [31:0] brand_w2;
	} entry_t;

	typedef enum logic [1:0] {
		CO_HOLD,
		CO_INSERT,
		CO_REMOVE,
		CO_SCAN
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [7:0]  key;
		entry_t      entry;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} ctrl_state_t;

endpackage
`default_nettype wire

FILE: design/positional_record_list.sv
// top level of the positional record list: sequencer plus chain of record cells
//
// Ordered list of up to CAPACITY records (size, price, color and brand tags).
// A command transfer happens on a rising edge with start high and busy low;
// the result (status, touched index, count after the command) sits on result
// for exactly one cycle with done high, and the receiver cannot stall it.
// Append, insert, remove, clear and unused codes need no search: for a valid
// append, insert or remove the cells shift or load at the transfer edge, done
// follows in the next cycle, and busy stays low so a new command can be
// taken every cycle. Update by size sends a search token down the chain one
// cell per cycle from index 0; busy stays high until the first match is found
// or no entry matches. No clearing pass after reset: entries at or above the
// count never reach a result before they are written.
`default_nettype none
module positional_record_list
	import prl_pkg::*;
#(
	parameter int CAPACITY = 512
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t request,
	output logic      busy,
	output logic      done,
	output res_t      result
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// broadcast from the sequencer to every cell, and the token inject into cell 0
	cell_ctl_t        ctl;
	logic [IDX_W-1:0] target;
	logic [CNT_W-1:0] count;
	logic             inject;

	// chain wiring
	entry_t              cell_entry [CAPACITY];
	logic [CAPACITY-1:0] tok_out;
	logic [CAPACITY-1:0] hits;
	logic                hit_any;

	// at most one cell holds the token, so a plain or of the hits suffices
	assign hit_any = |hits;

	prl_ctrl #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result),
		.ctl     (ctl),
		.target  (target),
		.count   (count),
		.inject  (inject),
		.hit_any (hit_any)
	);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_chain
		entry_t left_e;
		entry_t right_e;
		logic   tok_in;

		// ends of the chain see their own entry
		if (g == 0) begin : g_first
			assign left_e = cell_entry[g];
			assign tok_in = inject;
		end else begin : g_mid_l
			assign left_e = cell_entry[g-1];
			assign tok_in = tok_out[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_e = cell_entry[g];
		end else begin : g_mid_r
			assign right_e = cell_entry[g+1];
		end

		prl_cell #(
			.IDX_W (IDX_W),
			.CNT_W (CNT_W),
			.INDEX (g)
		) u_rec (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.target      (target),
			.count       (count),
			.left_entry  (left_e),
			.right_entry (right_e),
			.token_in    (tok_in),
			.entry       (cell_entry[g]),
			.token_out   (tok_out[g]),
			.hit         (hits[g])
		);
	end

endmodule
`default_nettype wire

FILE: design/prl_cell.sv
// one storage cell of the record chain: holds one entry and a search token
`default_nettype none
module prl_cell
	import prl_pkg::*;
#(
	parameter int IDX_W = 9,
	parameter int CNT_W = 10,
	parameter int INDEX = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctl_t        ctl,
	input  wire logic [IDX_W-1:0] target,
	input  wire logic [CNT_W-1:0] count,
	input  wire entry_t           left_entry,
	input  wire entry_t           right_entry,
	input  wire logic             token_in,
	output entry_t                entry,
	output logic                  token_out,
	output logic                  hit
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

	entry_t entry_q;
	entry_t entry_nxt;
	logic   token_q;
	logic   live;

	assign live      = MY_CNT < count;
	assign hit       = token_q && live && (ctl.op == CO_SCAN) && (entry_q.size == ctl.key);
	assign token_out = token_q && !hit && (ctl.op == CO_SCAN);
	assign entry     = entry_q;

	always_comb begin
		entry_nxt = entry_q;
		unique case (ctl.op)
			CO_INSERT: begin
				priority if (MY_IDX == target) begin
					entry_nxt = ctl.entry;
				end else if (MY_IDX > target) begin
					entry_nxt = left_entry;
				end else begin
					entry_nxt = entry_q;
				end
			end
			CO_REMOVE: begin
				if (MY_IDX >= target) begin
					entry_nxt = right_entry;
				end
			end
			CO_SCAN: begin
				if (hit) begin
					entry_nxt = ctl.entry;
				end
			end
			default: begin
				entry_nxt = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
		end else begin
			token_q <= token_in;
		end
	end

endmodule
`default_nettype wire

FILE: design/prl_ctrl.sv
// command sequencer: count, status, search bookkeeping and result register
`default_nettype none
`include "positional_record_list_defines.svh"
module prl_ctrl
	import prl_pkg::*;
#(
	parameter int CAPACITY = 512,
	parameter int IDX_W    = 9,
	parameter int CNT_W    = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire req_t             request,
	output logic                  busy,
	output logic                  done,
	output res_t                  result,
	output cell_ctl_t             ctl,
	output logic [IDX_W-1:0]      target,
	output logic [CNT_W-1:0]      count,
	output logic                  inject,
	input  wire logic             hit_any
);

	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	ctrl_state_t      state_q;
	ctrl_state_t      state_nxt;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [CNT_W-1:0] scan_idx_q;
	logic             hit_seen_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [7:0]       key_q;
	entry_t           req_entry_q;
	entry_t           in_entry;
	logic             done_q;
	res_t             result_q;
	res_t             res_nxt;
	logic             res_load;
	logic             accept;
	logic             full;
	logic             scan_end;
	logic [CMP_W-1:0] pos_cmp;
	logic [CMP_W-1:0] cnt_cmp;

	function automatic logic [TOUCH_W-1:0] to_touched(input logic [IDX_W-1:0] idx);
		logic [IDX_W+TOUCH_W-1:0] w;
		w = {{TOUCH_W{1'b0}}, idx};
		return w[TOUCH_W-1:0];
	endfunction

	function automatic logic [OUT_COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
		logic [CNT_W+OUT_COUNT_W-1:0] w;
		w = {{OUT_COUNT_W{1'b0}}, c};
		return w[OUT_COUNT_W-1:0];
	endfunction

	assign busy     = (state_q == S_SCAN);
	assign accept   = start && !busy;
	assign full     = (count_q >= CAP_C);
	assign pos_cmp  = CMP_W'(request.position);
	assign cnt_cmp  = CMP_W'(count_q);
	assign scan_end = hit_seen_q || (scan_idx_q == count_q);
	assign count    = count_q;
	assign done     = done_q;
	assign result   = result_q;

	always_comb begin
		in_entry.size     = request.item_size;
		in_entry.price    = request.item_price;
		in_entry.color_w0 = request.color_w0;
		in_entry.color_w1 = request.color_w1;
		in_entry.color_w2 = request.color_w2;
		in_entry.brand_w0 = request.brand_w0;
		in_entry.brand_w1 = request.brand_w1;
		in_entry.brand_w2 = request.brand_w2;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && request.command == CMD_UPDATE) begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// outputs toward the chain and the result register
	always_comb begin
		ctl.op    = CO_HOLD;
		ctl.key   = key_q;
		ctl.entry = in_entry;
		target    = '0;
		inject    = 1'b0;
		count_nxt = count_q;
		res_load  = 1'b0;
		res_nxt.status        = ST_OK;
		res_nxt.touched_index = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_load = 1'b1;
					unique case (request.command)
						CMD_APPEND: begin
							if (full) begin
								res_nxt.status = ST_FULL;
							end else begin
								ctl.op    = CO_INSERT;
								target    = count_q[IDX_W-1:0];
								res_nxt.touched_index = to_touched(count_q[IDX_W-1:0]);
								count_nxt = count_q + 1'b1;
							end
						end
						CMD_INSERT: begin
							priority if (full) begin
								res_nxt.status = ST_FULL;
							end else if (pos_cmp > cnt_cmp) begin
								res_nxt.status = ST_BADPOS;
							end else begin
								ctl.op    = CO_INSERT;
								target    = IDX_W'(request.position);
								res_nxt.touched_index = request.position;
								count_nxt = count_q + 1'b1;
							end
						end
						CMD_REMOVE: begin
							if (pos_cmp >= cnt_cmp) begin
								res_nxt.status = ST_BADPOS;
							end else begin
								ctl.op    = CO_REMOVE;
								target    = IDX_W'(request.position);
								res_nxt.touched_index = request.position;
								count_nxt = count_q - 1'b1;
							end
						end
						CMD_UPDATE: begin
							res_load = 1'b0;
							inject   = 1'b1;
						end
						CMD_CLEAR: begin
							count_nxt = '0;
						end
						default: begin
							res_nxt.status = ST_OK;
						end
					endcase
				end
			end
			S_SCAN: begin
				ctl.op    = CO_SCAN;
				ctl.entry = req_entry_q;
				priority if (hit_seen_q) begin
					res_load = 1'b1;
					res_nxt.touched_index = to_touched(hit_idx_q);
				end else if (scan_idx_q == count_q) begin
					res_load = 1'b1;
					res_nxt.status = ST_NOKEY;
				end else begin
					res_load = 1'b0;
				end
			end
			default: begin
				ctl.op = CO_HOLD;
			end
		endcase
		res_nxt.entry_count = to_count(count_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			hit_seen_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			count_q    <= count_nxt;
			hit_seen_q <= hit_any;
			done_q     <= res_load;
			if (accept) begin
				scan_idx_q <= '0;
			end else if (state_q == S_SCAN && !scan_end) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_idx_q <= scan_idx_q[IDX_W-1:0];
		if (accept) begin
			key_q       <= request.match_size;
			req_entry_q <= in_entry;
		end
		if (res_load) begin
			result_q <= res_nxt;
		end
	end

	`PRL_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CAP_C, "entry count above capacity")
	`PRL_ASSERT_SAME(a_hit_in_scan, hit_any, state_q == S_SCAN, "cell hit outside a search")
	`PRL_ASSERT_SAME(a_scan_range, state_q == S_SCAN, scan_idx_q <= count_q, "search ran past the list")
	`PRL_ASSERT_NEXT(a_quick_done, accept && request.command != CMD_UPDATE, done_q, "one-cycle command gave no result")

endmodule
`default_nettype wire
